@@ rtl/tsvf_pkg.sv @@
// Shared types, register map and reset values of the state variable filter.
package tsvf_pkg;

  // Default sizes for the top-level parameters
  localparam int CHANNELS_DEF     = 2;
  localparam int SAMPLE_WIDTH_DEF = 24;

  // Depth of the queue between front and back end
  localparam int QUEUE_DEPTH = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRATOR_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHELF_GAIN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COMP_GAIN       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HP_NORM         = 3'd6;

  // Coefficient widths
  localparam int GAIN_W = 24;
  localparam int DAMP_W = 24;
  localparam int SHELF_W = 24;
  localparam int COMP_W = 23;
  localparam int NORM_W = 23;
  // 2R + 4g, both in Q.22
  localparam int COEF_W = 27;

  // Register reset values
  localparam logic [GAIN_W-1:0]         GAIN_RST  = 24'd74760;
  localparam logic [DAMP_W-1:0]         DAMP_RST  = 24'd2097152;
  localparam logic signed [SHELF_W-1:0] SHELF_RST = 24'sd1048576;
  localparam logic [COMP_W-1:0]         COMP_RST  = 23'd4194304;
  localparam logic [NORM_W-1:0]         NORM_RST  = 23'd3896600;
  localparam logic [COEF_W-1:0]         COEF_RST  = 27'd4493344;

  // Output selection
  typedef enum logic [2:0] {
    MODE_LP,
    MODE_BP,
    MODE_HP,
    MODE_UBP,
    MODE_SHELF,
    MODE_NOTCH,
    MODE_ALLPASS,
    MODE_PEAK
  } mode_e;

  // Settings handed from the register file to front and back end
  typedef struct packed {
    mode_e                     mode;
    logic                      enable;
    logic [GAIN_W-1:0]         gain;
    logic [DAMP_W-1:0]         damp;
    logic signed [SHELF_W-1:0] shelf;
    logic [COMP_W-1:0]         comp;
    logic [NORM_W-1:0]         norm;
    logic [COEF_W-1:0]         coef;
  } cfg_t;

endpackage

@@ rtl/tpt_state_variable_filter.sv @@
// Top level of the multichannel state variable filter.
//
// Samples enter on the s_axis channel: tdata carries the signed sample,
// tuser the channel number. Results leave on the m_axis channel, one per
// input item, in order. The user must write registers over the cfg channel
// (index, data) only while no item is in flight; the block does not enforce
// this. cfg_ready_o is always high. A front end takes items into a
// two-entry queue; the back end runs the filter for one item at a time on a
// single 33x28 multiplier that is reused for all seven products, one
// product per step of its sequencer, and takes no new item until the last
// result is loaded; a bypassed item (enable 0) skips the multiply chain.
// Reset clears the integrator states of every channel, loads the register
// reset values and empties the queue and the output register.
// When the receiver stalls, the result holds in the output register; the
// back end finishes its next item and waits, and the input keeps taking
// items until the queue is full.
module tpt_state_variable_filter #(
  parameter int CHANNELS     = tsvf_pkg::CHANNELS_DEF,
  parameter int SAMPLE_WIDTH = tsvf_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Input items
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: sample_in
  input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,
  // tuser: channel
  input  logic                                  s_axis_tuser,
  // Result items
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // tdata: sample_out
  output logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] m_axis_tdata,
  // Register writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [tsvf_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [tsvf_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ITEM_W  = SAMPLE_WIDTH + CH_W + 1;
  localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

  tsvf_pkg::cfg_t    cfg;
  logic              q_push, q_full, q_pop, q_empty;
  logic [ITEM_W-1:0] q_wdata, q_rdata;

  tsvf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tsvf_front #(
    .CHANNELS     (CHANNELS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .CH_W         (CH_W),
    .ITEM_W       (ITEM_W)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sample_i      (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .channel_i     (s_axis_tuser),
    .enable_i      (cfg.enable),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_wdata_o     (q_wdata)
  );

  tsvf_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (tsvf_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  tsvf_back #(
    .CHANNELS     (CHANNELS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .CH_W         (CH_W),
    .ITEM_W       (ITEM_W),
    .TDATA_W      (TDATA_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .q_empty_i     (q_empty),
    .q_rdata_i     (q_rdata),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

@@ rtl/tsvf_cfg.sv @@
// Configuration register file with the precomputed 2R+4g coefficient.
module tsvf_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tsvf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tsvf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output tsvf_pkg::cfg_t                   cfg_o
);

  tsvf_pkg::mode_e                            mode_q, mode_d;
  logic                                       enable_q, enable_d;
  logic [tsvf_pkg::GAIN_W-1:0]                gain_q, gain_d;
  logic [tsvf_pkg::DAMP_W-1:0]                damp_q, damp_d;
  logic signed [tsvf_pkg::SHELF_W-1:0]        shelf_q, shelf_d;
  logic [tsvf_pkg::COMP_W-1:0]                comp_q, comp_d;
  logic [tsvf_pkg::NORM_W-1:0]                norm_q, norm_d;
  logic [tsvf_pkg::COEF_W-1:0]                coef_q, coef_d;

  // Writes are always taken
  assign cfg_ready_o = 1'b1;

  // Decode the register write
  always_comb begin
    mode_d   = mode_q;
    enable_d = enable_q;
    gain_d   = gain_q;
    damp_d   = damp_q;
    shelf_d  = shelf_q;
    comp_d   = comp_q;
    norm_d   = norm_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tsvf_pkg::REG_FILTER_MODE:     mode_d   = tsvf_pkg::mode_e'(cfg_data_i[2:0]);
        tsvf_pkg::REG_ENABLE:          enable_d = cfg_data_i[0];
        tsvf_pkg::REG_INTEGRATOR_GAIN: gain_d   = cfg_data_i[tsvf_pkg::GAIN_W-1:0];
        tsvf_pkg::REG_DAMPING:         damp_d   = cfg_data_i[tsvf_pkg::DAMP_W-1:0];
        tsvf_pkg::REG_SHELF_GAIN:      shelf_d  = $signed(cfg_data_i[tsvf_pkg::SHELF_W-1:0]);
        tsvf_pkg::REG_COMP_GAIN:       comp_d   = cfg_data_i[tsvf_pkg::COMP_W-1:0];
        tsvf_pkg::REG_HP_NORM:         norm_d   = cfg_data_i[tsvf_pkg::NORM_W-1:0];
        default: ;
      endcase
    end
  end

  // Register 2R + 4g from the gain and damping registers, so it follows them in the next cycle
  assign coef_d = tsvf_pkg::COEF_W'({damp_q, 1'b0}) + tsvf_pkg::COEF_W'({gain_q, 2'b00});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= tsvf_pkg::MODE_LP;
      enable_q <= 1'b0;
      gain_q   <= tsvf_pkg::GAIN_RST;
      damp_q   <= tsvf_pkg::DAMP_RST;
      shelf_q  <= tsvf_pkg::SHELF_RST;
      comp_q   <= tsvf_pkg::COMP_RST;
      norm_q   <= tsvf_pkg::NORM_RST;
      coef_q   <= tsvf_pkg::COEF_RST;
    end else begin
      mode_q   <= mode_d;
      enable_q <= enable_d;
      gain_q   <= gain_d;
      damp_q   <= damp_d;
      shelf_q  <= shelf_d;
      comp_q   <= comp_d;
      norm_q   <= norm_d;
      coef_q   <= coef_d;
    end
  end

  always_comb begin
    cfg_o.mode   = mode_q;
    cfg_o.enable = enable_q;
    cfg_o.gain   = gain_q;
    cfg_o.damp   = damp_q;
    cfg_o.shelf  = shelf_q;
    cfg_o.comp   = comp_q;
    cfg_o.norm   = norm_q;
    cfg_o.coef   = coef_q;
  end

endmodule

@@ rtl/tsvf_front.sv @@
// Input side: accept items, fold the channel number and tag bypassed items.
module tsvf_front #(
  parameter int CHANNELS     = tsvf_pkg::CHANNELS_DEF,
  parameter int SAMPLE_WIDTH = tsvf_pkg::SAMPLE_WIDTH_DEF,
  parameter int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  parameter int ITEM_W       = SAMPLE_WIDTH + CH_W + 1
) (
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                    channel_i,
  input  logic                    enable_i,
  input  logic                    q_full_i,
  output logic                    q_push_o,
  output logic [ITEM_W-1:0]       q_wdata_o
);

  logic [CH_W-1:0] ch_idx;

  // Take items while the queue has room
  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i;

  // Fold the channel number into the implemented channels
  assign ch_idx = (CHANNELS == 1) ? '0 : CH_W'(channel_i);

  // Queue entry: bypass flag, channel, sample
  assign q_wdata_o = {!enable_i, ch_idx, sample_i};

endmodule

@@ rtl/tsvf_fifo.sv @@
// Short queue between front and back end.
module tsvf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tsvf_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/tsvf_back.sv @@
// Filter engine: sequencer around one shared multiplier, integrator states, output register.
module tsvf_back #(
  parameter int CHANNELS     = tsvf_pkg::CHANNELS_DEF,
  parameter int SAMPLE_WIDTH = tsvf_pkg::SAMPLE_WIDTH_DEF,
  parameter int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  parameter int ITEM_W       = SAMPLE_WIDTH + CH_W + 1,
  parameter int TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tsvf_pkg::cfg_t     cfg_i,
  input  logic               q_empty_i,
  input  logic [ITEM_W-1:0]  q_rdata_i,
  output logic               q_pop_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata
);

  // Multiplier operands: signed 33 x signed 28
  localparam int PA_W   = 33;
  localparam int PB_W   = 28;
  localparam int PROD_W = PA_W + PB_W;
  localparam int ACC_W  = 40;
  localparam int TERM_W = 40;
  localparam int LO_W   = 16;
  localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] OUT_MIN = -OUT_MAX - 64'sd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_ACC,
    ST_MUL_NH,
    ST_MUL_NL,
    ST_HP,
    ST_MUL_GH,
    ST_BP,
    ST_MUL_GB,
    ST_LP,
    ST_UBP,
    ST_MUL_Y,
    ST_OUT
  } state_e;

  state_e                    state_q;
  logic                      out_valid_q;
  logic [SAMPLE_WIDTH-1:0]   out_q;

  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic [CH_W-1:0]                ch_q;
  logic                           byp_q;

  logic signed [31:0]        z_one_q [CHANNELS];
  logic signed [31:0]        z_two_q [CHANNELS];

  logic signed [PROD_W-1:0]  prod_q, hi_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [31:0]        hp_q, bp_q, lp_q, ubp_q;
  logic signed [TERM_W-1:0]  gh_q, gb_q, ap_q;

  logic signed [PA_W-1:0]    mul_a;
  logic signed [PB_W-1:0]    mul_b;
  logic                      mul_en;
  logic signed [63:0]        prod_w, rs20, rs21, rs22, norm_sum, y_full;
  logic signed [31:0]        z1, z2;
  logic [SAMPLE_WIDTH-1:0]   y_sat;
  logic                      out_free, item_take;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return 32'(v);
  endfunction

  assign z1 = z_one_q[ch_q];
  assign z2 = z_two_q[ch_q];

  assign out_free  = !out_valid_q || m_axis_tready;
  assign item_take = (state_q == ST_IDLE) && !q_empty_i;
  assign q_pop_o   = item_take;

  // Rounded shifts of the last product, ties toward plus infinity
  always_comb begin
    prod_w   = 64'(prod_q);
    rs20     = (prod_w + 64'sd524288) >>> 20;
    rs21     = (prod_w + 64'sd1048576) >>> 21;
    rs22     = (prod_w + 64'sd2097152) >>> 22;
    norm_sum = ((64'(hi_q) <<< LO_W) + prod_w + 64'sd2097152) >>> 22;
  end

  // Select multiplier operands for the current step
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      ST_MUL_A: begin
        mul_en = 1'b1;
        mul_a  = PA_W'(z1);
        mul_b  = PB_W'($signed({1'b0, cfg_i.coef}));
      end
      ST_MUL_NH: begin
        mul_en = 1'b1;
        mul_a  = PA_W'($signed(acc_q[ACC_W-1:LO_W]));
        mul_b  = PB_W'($signed({1'b0, cfg_i.norm}));
      end
      ST_MUL_NL: begin
        mul_en = 1'b1;
        mul_a  = PA_W'($signed({1'b0, acc_q[LO_W-1:0]}));
        mul_b  = PB_W'($signed({1'b0, cfg_i.norm}));
      end
      ST_MUL_GH: begin
        mul_en = 1'b1;
        mul_a  = PA_W'(hp_q);
        mul_b  = PB_W'($signed({1'b0, cfg_i.gain}));
      end
      ST_MUL_GB: begin
        mul_en = 1'b1;
        mul_a  = PA_W'(bp_q);
        mul_b  = PB_W'($signed({1'b0, cfg_i.gain}));
      end
      ST_LP: begin
        mul_en = 1'b1;
        mul_a  = PA_W'(bp_q);
        mul_b  = PB_W'($signed({1'b0, cfg_i.damp}));
      end
      ST_MUL_Y: begin
        mul_en = 1'b1;
        mul_b  = PB_W'($signed({1'b0, cfg_i.comp}));
        unique case (cfg_i.mode)
          tsvf_pkg::MODE_LP: mul_a = PA_W'(lp_q);
          tsvf_pkg::MODE_BP: mul_a = PA_W'(bp_q);
          tsvf_pkg::MODE_HP: mul_a = PA_W'(hp_q);
          default: begin
            mul_a = PA_W'(ubp_q);
            mul_b = PB_W'($signed(cfg_i.shelf));
          end
        endcase
      end
      default: ;
    endcase
  end

  // Form the selected response
  always_comb begin
    if (byp_q) begin
      y_full = 64'(x_q);
    end else begin
      unique case (cfg_i.mode) inside
        tsvf_pkg::MODE_LP, tsvf_pkg::MODE_BP, tsvf_pkg::MODE_HP: y_full = rs22;
        tsvf_pkg::MODE_UBP:     y_full = 64'(ubp_q);
        tsvf_pkg::MODE_SHELF:   y_full = 64'(x_q) + rs20;
        tsvf_pkg::MODE_NOTCH:   y_full = 64'(x_q) - 64'(ubp_q);
        tsvf_pkg::MODE_ALLPASS: y_full = 64'(x_q) - 64'(ap_q);
        default:                y_full = 64'(lp_q) - 64'(hp_q);
      endcase
    end
    if (y_full > OUT_MAX) begin
      y_sat = SAMPLE_WIDTH'(OUT_MAX);
    end else if (y_full < OUT_MIN) begin
      y_sat = SAMPLE_WIDTH'(OUT_MIN);
    end else begin
      y_sat = SAMPLE_WIDTH'(y_full);
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (item_take) begin
      x_q   <= q_rdata_i[SAMPLE_WIDTH-1:0];
      ch_q  <= q_rdata_i[SAMPLE_WIDTH+CH_W-1:SAMPLE_WIDTH];
      byp_q <= q_rdata_i[ITEM_W-1];
    end
    case (state_q)
      ST_ACC:    acc_q <= ACC_W'(64'(x_q) - rs22 - 64'(z2));
      ST_MUL_NL: hi_q  <= prod_q;
      ST_HP:     hp_q  <= sat32(norm_sum);
      ST_BP: begin
        gh_q <= TERM_W'(rs20);
        bp_q <= sat32(rs20 + 64'(z1));
      end
      ST_LP: begin
        gb_q <= TERM_W'(rs20);
        lp_q <= sat32(rs20 + 64'(z2));
      end
      ST_UBP: begin
        ubp_q <= sat32(rs21);
        ap_q  <= TERM_W'(rs20);
      end
      default: ;
    endcase
  end

  // Integrator states, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        z_one_q[i] <= '0;
        z_two_q[i] <= '0;
      end
    end else begin
      if (state_q == ST_MUL_GB) begin
        z_one_q[ch_q] <= sat32(64'(gh_q) + 64'(bp_q));
      end
      if (state_q == ST_UBP) begin
        z_two_q[ch_q] <= sat32(64'(gb_q) + 64'(lp_q));
      end
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // Load a new result or drop the one just taken
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            state_q <= q_rdata_i[ITEM_W-1] ? ST_OUT : ST_MUL_A;
          end
        end
        ST_MUL_A:  state_q <= ST_ACC;
        ST_ACC:    state_q <= ST_MUL_NH;
        ST_MUL_NH: state_q <= ST_MUL_NL;
        ST_MUL_NL: state_q <= ST_HP;
        ST_HP:     state_q <= ST_MUL_GH;
        ST_MUL_GH: state_q <= ST_BP;
        ST_BP:     state_q <= ST_MUL_GB;
        ST_MUL_GB: state_q <= ST_LP;
        ST_LP:     state_q <= ST_UBP;
        ST_UBP:    state_q <= ST_MUL_Y;
        ST_MUL_Y:  state_q <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            out_q   <= y_sat;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_W'(out_q);

endmodule

@@ rtl/tsvf_checker.sv @@
// Port-level checks for the state variable filter, bound to the top level.
module tsvf_checker #(
  parameter int TDATA_W = 24
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // No result is offered while in reset
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result offered during reset");

  // The input only stalls after an item filled the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("input stalled without an accepted item");

endmodule

bind tpt_state_variable_filter tsvf_checker #(
  .TDATA_W (((SAMPLE_WIDTH + 7) / 8) * 8)
) u_tsvf_checker (.*);

@@ sim/svf_result_checker.sv @@
// Checker for the state variable filter: predicts each result and compares it.
module svf_result_checker
  import tsvf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [23:0]           in_sample_i,
  input  logic                  in_chan_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [23:0]           out_sample_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    errors_o,
  output int                    pending_o
);

  localparam int SAMPLE_W = SAMPLE_WIDTH_DEF;

  typedef struct {
    mode_e                     mode;
    logic                      enable;
    logic [GAIN_W-1:0]         gain;
    logic [DAMP_W-1:0]         damp;
    logic signed [SHELF_W-1:0] shelf;
    logic [COMP_W-1:0]         comp;
    logic [NORM_W-1:0]         norm;
  } filt_regs_t;

  filt_regs_t        regs;
  logic signed [31:0] integ_one [CHANNELS_DEF];
  logic signed [31:0] integ_two [CHANNELS_DEF];
  logic [SAMPLE_W-1:0] expected_samples [$];
  logic [SAMPLE_W-1:0] want_sample;
  int                mismatches;

  // Shift right with rounding to nearest, ties toward plus infinity
  function automatic longint round_shr(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Run one sample through the filter and advance that channel's integrators
  function automatic logic [SAMPLE_W-1:0] filter_step(logic [SAMPLE_W-1:0] smp, logic chan);
    longint x, g, r, k, z1, z2, acc, hp, bp, lp, ubp, y;
    x = longint'($signed(smp));
    g = longint'(regs.gain);
    r = longint'(regs.damp);
    k = longint'(regs.shelf);
    // bypass leaves the states alone
    if (!regs.enable) return smp;
    z1 = integ_one[chan];
    z2 = integ_two[chan];
    acc = x - round_shr(((r <<< 1) + (g <<< 2)) * z1, 22) - z2;
    hp  = clamp(round_shr(acc * longint'(regs.norm), 22), 32);
    bp  = clamp(round_shr(hp * g, 20) + z1, 32);
    lp  = clamp(round_shr(bp * g, 20) + z2, 32);
    ubp = clamp(round_shr(r * bp, 21), 32);
    integ_one[chan] = 32'(clamp(round_shr(g * hp, 20) + bp, 32));
    integ_two[chan] = 32'(clamp(round_shr(g * bp, 20) + lp, 32));
    case (regs.mode)
      MODE_LP:      y = round_shr(lp * longint'(regs.comp), 22);
      MODE_BP:      y = round_shr(bp * longint'(regs.comp), 22);
      MODE_HP:      y = round_shr(hp * longint'(regs.comp), 22);
      MODE_UBP:     y = ubp;
      MODE_SHELF:   y = x + round_shr(ubp * k, 20);
      MODE_NOTCH:   y = x - ubp;
      MODE_ALLPASS: y = x - round_shr(r * bp, 20);
      default:      y = lp - hp; // peak
    endcase
    return SAMPLE_W'(clamp(y, SAMPLE_W));
  endfunction

  // Track register writes, predict on input items, compare on result items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.mode   = MODE_LP;
      regs.enable = 1'b0;
      regs.gain   = GAIN_RST;
      regs.damp   = DAMP_RST;
      regs.shelf  = SHELF_RST;
      regs.comp   = COMP_RST;
      regs.norm   = NORM_RST;
      for (int c = 0; c < CHANNELS_DEF; c++) begin
        integ_one[c] = '0;
        integ_two[c] = '0;
      end
      expected_samples.delete();
      mismatches = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_FILTER_MODE:     regs.mode   = mode_e'(cfg_data_i[2:0]);
          REG_ENABLE:          regs.enable = cfg_data_i[0];
          REG_INTEGRATOR_GAIN: regs.gain   = cfg_data_i[GAIN_W-1:0];
          REG_DAMPING:         regs.damp   = cfg_data_i[DAMP_W-1:0];
          REG_SHELF_GAIN:      regs.shelf  = $signed(cfg_data_i[SHELF_W-1:0]);
          REG_COMP_GAIN:       regs.comp   = cfg_data_i[COMP_W-1:0];
          REG_HP_NORM:         regs.norm   = cfg_data_i[NORM_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result item: got %h", out_sample_i);
        end else begin
          want_sample = expected_samples.pop_front();
          if (out_sample_i !== want_sample) begin
            mismatches++;
            if (mismatches <= 10)
              $display("sample_out wrong: expected %h got %h", want_sample, out_sample_i);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_samples.push_back(filter_step(in_sample_i, in_chan_i));
      errors_o  <= mismatches;
      pending_o <= expected_samples.size();
    end
  end

endmodule

@@ sim/tb_tpt_state_variable_filter.sv @@
// Testbench top for the state variable filter: stimulus, flow control and verdict.
module tb_tpt_state_variable_filter;
  import tsvf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES = 15;
  localparam int ITEMS_PER_PHASE = 40;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [23:0]           s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [23:0]           m_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatch_total;
  int pending_items;
  int cycle_count;
  int send_burst;
  int recv_burst;
  int results_seen;

  // register values to program and which of them to write
  logic [CFG_DATA_W-1:0] reg_image [8];
  logic [7:0]            reg_dirty;

  tpt_state_variable_filter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  svf_result_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_tvalid),
    .in_ready_i   (s_tready),
    .in_sample_i  (s_tdata),
    .in_chan_i    (s_tuser),
    .out_valid_i  (m_tvalid),
    .out_ready_i  (m_tready),
    .out_sample_i (m_tdata),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .errors_o     (mismatch_total),
    .pending_o    (pending_items)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Idle cycles before the next item; runs of back-to-back items now and then
  function automatic int draw_gap(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(20, 60);
    return $urandom_range(0, 10);
  endfunction

  // Offer one item and hold it until accepted
  task automatic send_item(input logic [23:0] smp, input logic chan);
    int gap;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tuser  <= chan;
    do @(posedge clk_i); while (!s_tready);
  endtask

  // Write every marked register, back to back
  task automatic write_regs();
    for (int i = 0; i < 8; i++) begin
      if (reg_dirty[i]) begin
        cfg_valid <= 1'b1;
        cfg_index <= i[CFG_IDX_W-1:0];
        cfg_data  <= reg_image[i];
        do @(posedge clk_i); while (!cfg_ready);
      end
    end
    cfg_valid <= 1'b0;
  endtask

  // Stop offering and wait until every result has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_items != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [23:0] random_sample();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) return ($urandom_range(0, 1) != 0) ? 24'h7fffff : 24'h800000;
    if (kind <= 2) return 24'($signed($urandom_range(0, 2000)) - 1000);
    return 24'($urandom());
  endfunction

  // Receiver: random stalls, plus long hold-offs that back up the input
  initial begin
    int stall;
    m_tready <= 1'b0;
    recv_burst = 0;
    results_seen = 0;
    wait (rst_ni);
    forever begin
      stall = draw_gap(recv_burst);
      if (results_seen == 150 || results_seen == 450) stall = HOLD_CYCLES;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      results_seen++;
    end
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stimulus
  initial begin
    mode_e md;
    int    kind;
    int    gain_v;
    int    damp_v;
    int    norm_v;
    real   g_r;
    real   r_r;
    rst_ni    <= 1'b0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_FILTER_MODE;
    cfg_data  <= '0;
    send_burst = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Bypass out of reset: samples pass unchanged
    send_item(24'h7fffff, 1'b0);
    send_item(24'h800000, 1'b1);
    send_item(24'h000000, 1'b0);
    send_item(24'hffffff, 1'b1);
    drain();

    // Every output mode at default coefficients, full-scale samples
    reg_image[REG_FILTER_MODE]     = 24'(MODE_LP);
    reg_image[REG_ENABLE]          = 24'd1;
    reg_image[REG_INTEGRATOR_GAIN] = GAIN_RST;
    reg_image[REG_DAMPING]         = DAMP_RST;
    reg_image[REG_SHELF_GAIN]      = SHELF_RST;
    reg_image[REG_COMP_GAIN]       = 24'(COMP_RST);
    reg_image[REG_HP_NORM]         = 24'(NORM_RST);
    reg_image[REG_SPARE]           = 24'hffffff;
    md = md.first();
    do begin
      reg_image[REG_FILTER_MODE] = 24'(md);
      reg_dirty = (md == MODE_LP) ? 8'hff : 8'h01;
      write_regs();
      send_item(24'h7fffff, 1'b0);
      send_item(24'h800000, 1'b1);
      drain();
      md = md.next();
    end while (md != md.first());

    // Largest coefficients: drive every stage into saturation
    reg_image[REG_FILTER_MODE]     = 24'(MODE_SHELF);
    reg_image[REG_INTEGRATOR_GAIN] = 24'hffffff;
    reg_image[REG_DAMPING]         = 24'hffffff;
    reg_image[REG_SHELF_GAIN]      = 24'h800000;
    reg_image[REG_COMP_GAIN]       = 24'h7fffff;
    reg_image[REG_HP_NORM]         = 24'h7fffff;
    reg_dirty = 8'h7d;
    write_regs();
    send_item(24'h7fffff, 1'b0);
    send_item(24'h800000, 1'b0);
    send_item(24'h7fffff, 1'b1);
    drain();

    // Random phases: mostly stable filters, some arbitrary or extreme settings
    for (int p = 0; p < PHASES; p++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        gain_v = $urandom_range(2000, 1 << 21);
        damp_v = $urandom_range(1 << 19, 1 << 23);
        g_r = real'(gain_v) / 1048576.0;
        r_r = real'(damp_v) / 4194304.0;
        norm_v = $rtoi(4194304.0 / (1.0 + 2.0 * r_r * g_r + g_r * g_r) + 0.5);
        reg_image[REG_INTEGRATOR_GAIN] = 24'(gain_v);
        reg_image[REG_DAMPING]         = 24'(damp_v);
        reg_image[REG_HP_NORM]         = {1'($urandom()), 23'(norm_v)};
        reg_image[REG_COMP_GAIN]       = {1'($urandom()), 23'($urandom_range(1 << 21, 1 << 22))};
        reg_image[REG_SHELF_GAIN]      = 24'($urandom());
        reg_dirty = 8'($urandom()) | 8'h4f;
      end else begin
        reg_image[REG_INTEGRATOR_GAIN] = ($urandom_range(0, 1) != 0) ?
          (($urandom_range(0, 1) != 0) ? 24'hffffff : 24'h000000) : 24'($urandom());
        reg_image[REG_DAMPING] = ($urandom_range(0, 1) != 0) ?
          (($urandom_range(0, 1) != 0) ? 24'hffffff : 24'h000000) : 24'($urandom());
        reg_image[REG_SHELF_GAIN] = ($urandom_range(0, 1) != 0) ?
          (($urandom_range(0, 1) != 0) ? 24'h7fffff : 24'h800000) : 24'($urandom());
        reg_image[REG_COMP_GAIN] = ($urandom_range(0, 1) != 0) ?
          (($urandom_range(0, 1) != 0) ? 24'h7fffff : 24'h000000) : 24'($urandom());
        reg_image[REG_HP_NORM] = ($urandom_range(0, 1) != 0) ?
          (($urandom_range(0, 1) != 0) ? 24'h7fffff : 24'h000000) : 24'($urandom());
        reg_dirty = 8'($urandom()) | 8'h03;
      end
      // upper bits of the narrow registers are don't-care
      reg_image[REG_FILTER_MODE] = {21'($urandom()), 3'($urandom_range(0, 7))};
      reg_image[REG_ENABLE] = {23'($urandom()), 1'($urandom_range(0, 5) != 0)};
      reg_image[REG_SPARE]  = 24'($urandom());
      write_regs();
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_item(random_sample(), 1'($urandom_range(0, 1)));
      drain();
    end

    if (mismatch_total == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tsvf_pkg.sv
rtl/tsvf_cfg.sv
rtl/tsvf_front.sv
rtl/tsvf_fifo.sv
rtl/tsvf_back.sv
rtl/tpt_state_variable_filter.sv
rtl/tsvf_checker.sv
sim/svf_result_checker.sv
sim/tb_tpt_state_variable_filter.sv
